>>> rtl/feedback_delay_line_assert.svh
// Assertion macros for the feedback delay line.
`ifndef FEEDBACK_DELAY_LINE_ASSERT_SVH
`define FEEDBACK_DELAY_LINE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FDL_ASSERT_NOW(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("feedback_delay_line: check failed");

// Next-cycle implication, disabled while reset is asserted.
`define FDL_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("feedback_delay_line: check failed");

`endif

>>> rtl/fdl_pkg.sv
// Shared types and constants for the feedback delay line.
`default_nettype none

package fdl_pkg;

  // register field widths
  localparam int LEN_CFG_W   = 19;
  localparam int DELAY_CFG_W = 27;
  localparam int GAIN_W      = 16;
  localparam int WET_W       = 16;
  localparam int CFG_DATA_W  = 27;
  localparam int CFG_IDX_W   = 2;

  // coefficient operand of the shared multiplier
  localparam int COEF_W = 18;

  // reset values
  localparam int LEN_RESET   = 220500;
  localparam int DELAY_RESET = 22579200;
  localparam int GAIN_RESET  = 0;
  localparam int WET_RESET   = 32768;

  // mix and feedback scaling
  localparam int MIX_SHIFT  = 15;
  localparam int MIX_ONE    = 32768;
  localparam int MIX_HALF   = 16384;
  localparam int GAIN_SHIFT = 12;
  localparam int GAIN_HALF  = 2048;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ACTIVE_LENGTH = 2'd0,
    REG_DELAY_AMOUNT  = 2'd1,
    REG_FEEDBACK_GAIN = 2'd2,
    REG_WET_MIX       = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic start;  // load init + product
    logic en;     // accumulate product
  } mac_ctl_t;

endpackage

`default_nettype wire

>>> rtl/fdl_if.sv
// Request channels of the feedback delay line: input samples and results.
`default_nettype none

interface fdl_in_if #(
  parameter int SAMPLE_WIDTH = 16
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample_in;
  logic                           signal_present;

  modport source (output valid, sample_in, signal_present, input ready);
  modport sink   (input valid, sample_in, signal_present, output ready);
endinterface

interface fdl_out_if #(
  parameter int SAMPLE_WIDTH = 16
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample_out;
  logic                           delay_too_long;

  modport source (output valid, sample_out, delay_too_long, input ready);
  modport sink   (input valid, sample_out, delay_too_long, output ready);
endinterface

`default_nettype wire

>>> rtl/feedback_delay_line.sv
// Fractional feedback delay line with linear interpolation: top level.
//
// One audio sample per request. The block reads a circular store at the
// write position minus a fractional delay, interpolates between the two
// neighboring entries, mixes dry and wet by wet_mix, and writes input plus
// feedback times wet back at the write position. A normal sample passes
// through nine sequencer steps after acceptance; the last one posts its
// result once the output register is free or being emptied, and no new
// request is taken before then. The two store reads go through the
// single read port one after the other, and the five products (two
// interpolation taps, two mix terms, feedback) all pass through one
// multiply-accumulate unit. A sample whose delay exceeds the active length
// goes straight from acceptance to the posting step; it returns zero with
// delay_too_long set and leaves the store untouched. in_if.ready is high
// only between samples; a finished result waits in the output register
// and does not hold up the next sample until that sample's own result is
// ready. After reset, and after every write to active_length, a clearing
// pass zeroes every store entry with in_if.ready low; configuration
// writes are still taken during the pass, and a length write restarts it.
`default_nettype none

`include "feedback_delay_line_assert.svh"

module feedback_delay_line
  import fdl_pkg::*;
#(
  parameter int STORE_DEPTH         = 262144,
  parameter int SAMPLE_WIDTH        = 16,
  parameter int DELAY_FRACTION_BITS = 8
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  fdl_in_if.sink                     in_if,
  fdl_out_if.source                  out_if,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  // ---------------------------------------------------------------------
  // Derived widths and constants
  // ---------------------------------------------------------------------
  localparam int SW     = SAMPLE_WIDTH;
  localparam int F      = DELAY_FRACTION_BITS;
  localparam int FW     = (F > 0) ? F : 1;
  localparam int AW     = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int LW     = $clog2(STORE_DEPTH + 1);      // holds STORE_DEPTH
  localparam int SPAN_W = LW + F;                        // length << F
  localparam int DW     = ((SPAN_W > DELAY_CFG_W) ? SPAN_W : DELAY_CFG_W) + 1;
  localparam int CW     = ((LW > LEN_CFG_W) ? LW : LEN_CFG_W) + 1;
  localparam int ACC_W  = SW + 20;

  localparam int FRAC_ONE      = 1 << F;
  localparam int INTERP_HALF   = (F > 0) ? (1 << (F - 1)) : 0;
  localparam int LEN_RESET_EFF = (LEN_RESET > STORE_DEPTH) ? STORE_DEPTH : LEN_RESET;

  localparam logic [DW-1:0] FRAC_MASK = DW'(FRAC_ONE - 1);

  localparam logic signed [ACC_W-1:0] SAT_HI = {{(ACC_W-SW+1){1'b0}}, {(SW-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] SAT_LO = ~SAT_HI;

  typedef enum logic [3:0] {
    S_CLEAR,  // zeroing pass over the store
    S_IDLE,   // waiting for a sample
    S_WRAP,   // wrap read point, split index and fraction
    S_RD0,    // read first tap, form second index
    S_RD1,    // read second tap, first tap into MAC
    S_MAC1,   // second tap into MAC
    S_WET,    // latch wet, start dry term of mix
    S_MIX,    // wet term of mix
    S_FB,     // latch mix, start feedback product
    S_STORE,  // write store, advance position
    S_POST    // hand result to output register
  } state_t;

  // ---------------------------------------------------------------------
  // Helpers
  // ---------------------------------------------------------------------
  function automatic logic signed [SW-1:0] sat(input logic signed [ACC_W-1:0] v);
    logic signed [SW-1:0] res;
    if (v > SAT_HI) begin
      res = SAT_HI[SW-1:0];
    end else if (v < SAT_LO) begin
      res = SAT_LO[SW-1:0];
    end else begin
      res = v[SW-1:0];
    end
    return res;
  endfunction

  // Zero means one entry, anything beyond the store means the whole store.
  function automatic logic [LW-1:0] len_eff(input logic [LEN_CFG_W-1:0] v);
    logic [LW-1:0] res;
    if (v == '0) begin
      res = LW'(1);
    end else if (CW'(v) > CW'(STORE_DEPTH)) begin
      res = LW'(STORE_DEPTH);
    end else begin
      res = LW'(v);
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------
  state_t                  state_r;
  logic [AW-1:0]           clr_cnt_r;
  logic [AW-1:0]           pos_r;
  logic [LW-1:0]           len_r;
  logic [DELAY_CFG_W-1:0]  delay_r;
  logic signed [GAIN_W-1:0] gain_r;
  logic [WET_W-1:0]        wet_mix_r;

  logic                    out_valid_r;
  logic signed [SW-1:0]    out_sample_r;
  logic                    out_flag_r;

  logic signed [SW-1:0]    x_r;
  logic [DW-1:0]           diff_r;
  logic [AW-1:0]           i0_r;
  logic [AW-1:0]           i1_r;
  logic [FW-1:0]           frac_r;
  logic signed [SW-1:0]    wet_r;
  logic signed [SW-1:0]    mix_r;
  logic                    flag_r;

  // ---------------------------------------------------------------------
  // Address path
  // ---------------------------------------------------------------------
  logic                    accept;
  logic                    len_wr;
  logic                    post_fire;
  logic [SPAN_W-1:0]       span;
  logic [SPAN_W-1:0]       pos_fix;
  logic                    too_long;
  logic [DW-1:0]           diff_w;
  logic [DW-1:0]           rd_point;
  logic [AW-1:0]           i0_w;
  logic [DW-1:0]           frac_full;
  logic [LW-1:0]           i0_inc;
  logic [AW-1:0]           i1_nxt;
  logic [LW-1:0]           pos_inc;
  logic [AW-1:0]           pos_nxt;
  logic [WET_W-1:0]        wet_cfg;

  assign in_if.ready = (state_r == S_IDLE);
  assign accept      = in_if.valid && in_if.ready;

  // length write restarts the store; posting needs a free output register
  assign len_wr    = cfg_we && (cfg_reg_t'(cfg_index) == REG_ACTIVE_LENGTH);
  assign post_fire = (state_r == S_POST) && (!out_valid_r || out_if.ready);

  assign span     = SPAN_W'(len_r) << F;
  assign pos_fix  = SPAN_W'(pos_r) << F;
  assign too_long = DW'(delay_r) > DW'(span);
  assign diff_w   = DW'(pos_fix) - DW'(delay_r);

  // Negative read point wraps by one full length.
  assign rd_point  = diff_r[DW-1] ? (diff_r + DW'(span)) : diff_r;
  assign i0_w      = AW'(rd_point >> F);
  assign frac_full = rd_point & FRAC_MASK;

  assign i0_inc  = LW'(i0_r) + LW'(1);
  assign i1_nxt  = (i0_inc >= len_r) ? '0 : AW'(i0_inc);
  assign pos_inc = LW'(pos_r) + LW'(1);
  assign pos_nxt = (pos_inc >= len_r) ? '0 : AW'(pos_inc);

  assign wet_cfg = (cfg_data[WET_W-1:0] > WET_W'(MIX_ONE)) ? WET_W'(MIX_ONE)
                                                           : cfg_data[WET_W-1:0];

  // ---------------------------------------------------------------------
  // Store
  // ---------------------------------------------------------------------
  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  logic [SW-1:0]        wr_data;
  logic [AW-1:0]        rd_addr;
  logic [SW-1:0]        rd_data;

  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] fb_sum;
  logic signed [SW-1:0]    store_val;

  assign fb_sum    = (acc >>> GAIN_SHIFT) + ACC_W'(x_r);
  assign store_val = sat(fb_sum);

  assign wr_en   = (state_r == S_CLEAR) || (state_r == S_STORE);
  assign wr_addr = (state_r == S_CLEAR) ? clr_cnt_r : pos_r;
  assign wr_data = (state_r == S_CLEAR) ? '0 : store_val;
  assign rd_addr = (state_r == S_RD0) ? i0_r : i1_r;

  fdl_store #(
    .DEPTH (STORE_DEPTH),
    .WIDTH (SW)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // ---------------------------------------------------------------------
  // Shared MAC: operand selection per sequencer step
  // ---------------------------------------------------------------------
  mac_ctl_t                 mac_ctl;
  logic signed [SW-1:0]     mac_a;
  logic signed [COEF_W-1:0] mac_b;
  logic signed [ACC_W-1:0]  mac_init;

  always_comb begin
    mac_ctl  = '0;
    mac_a    = wet_r;
    mac_b    = '0;
    mac_init = '0;
    case (state_r)
      S_RD1: begin
        // y0 * (1 - frac) + rounding
        mac_ctl.start = 1'b1;
        mac_a         = rd_data;
        mac_b         = COEF_W'(FRAC_ONE) - COEF_W'(frac_r);
        mac_init      = ACC_W'(INTERP_HALF);
      end
      S_MAC1: begin
        // + y1 * frac
        mac_ctl.en = 1'b1;
        mac_a      = rd_data;
        mac_b      = COEF_W'(frac_r);
      end
      S_WET: begin
        // dry * (1 - wet_mix) + rounding
        mac_ctl.start = 1'b1;
        mac_a         = x_r;
        mac_b         = COEF_W'(MIX_ONE) - COEF_W'(wet_mix_r);
        mac_init      = ACC_W'(MIX_HALF);
      end
      S_MIX: begin
        // + wet * wet_mix
        mac_ctl.en = 1'b1;
        mac_a      = wet_r;
        mac_b      = COEF_W'(wet_mix_r);
      end
      S_FB: begin
        // feedback * wet + rounding
        mac_ctl.start = 1'b1;
        mac_a         = wet_r;
        mac_b         = COEF_W'(gain_r);
        mac_init      = ACC_W'(GAIN_HALF);
      end
      default: begin
        mac_ctl = '0;
      end
    endcase
  end

  fdl_mac #(
    .A_W   (SW),
    .ACC_W (ACC_W)
  ) u_mac (
    .clk  (clk),
    .ctl  (mac_ctl),
    .op_a (mac_a),
    .op_b (mac_b),
    .init (mac_init),
    .acc  (acc)
  );

  // ---------------------------------------------------------------------
  // Sequencer, configuration and output register
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
      len_r       <= LW'(LEN_RESET_EFF);
      delay_r     <= DELAY_CFG_W'(DELAY_RESET);
      gain_r      <= GAIN_W'(GAIN_RESET);
      wet_mix_r   <= WET_W'(WET_RESET);
    end else begin
      // a waiting result leaves on ready; a posted one takes its place
      out_valid_r <= post_fire || (out_valid_r && !out_if.ready);

      if (len_wr) begin
        // new length: restart position and zero the store
        len_r     <= len_eff(cfg_data[LEN_CFG_W-1:0]);
        pos_r     <= '0;
        clr_cnt_r <= '0;
        state_r   <= S_CLEAR;
      end else begin
        case (state_r)
          S_CLEAR: begin
            clr_cnt_r <= clr_cnt_r + AW'(1);
            if (clr_cnt_r == AW'(STORE_DEPTH - 1)) begin
              state_r <= S_IDLE;
            end
          end
          S_IDLE: begin
            if (accept) begin
              state_r <= too_long ? S_POST : S_WRAP;
            end
          end
          S_WRAP:  state_r <= S_RD0;
          S_RD0:   state_r <= S_RD1;
          S_RD1:   state_r <= S_MAC1;
          S_MAC1:  state_r <= S_WET;
          S_WET:   state_r <= S_MIX;
          S_MIX:   state_r <= S_FB;
          S_FB:    state_r <= S_STORE;
          S_STORE: begin
            pos_r   <= pos_nxt;
            state_r <= S_POST;
          end
          S_POST: begin
            // the previous result must be gone (or leaving) first
            if (post_fire) begin
              out_sample_r <= mix_r;
              out_flag_r   <= flag_r;
              state_r      <= S_IDLE;
            end
          end
          default: state_r <= S_CLEAR;
        endcase
      end

      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_ACTIVE_LENGTH: ;  // taken above with the store restart
          REG_DELAY_AMOUNT:  delay_r   <= cfg_data[DELAY_CFG_W-1:0];
          REG_FEEDBACK_GAIN: gain_r    <= cfg_data[GAIN_W-1:0];
          REG_WET_MIX:       wet_mix_r <= wet_cfg;
          default: ;
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------
  // Datapath registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (accept) begin
      x_r    <= in_if.signal_present ? in_if.sample_in : '0;
      diff_r <= diff_w;
      mix_r  <= '0;        // stays zero for a too-long delay
      flag_r <= too_long;
    end
    case (state_r)
      S_WRAP: begin
        i0_r   <= i0_w;
        frac_r <= frac_full[FW-1:0];
      end
      S_RD0:   i1_r  <= i1_nxt;
      S_WET:   wet_r <= acc[F +: SW];          // floor(sum / 2^F)
      S_FB:    mix_r <= sat(acc >>> MIX_SHIFT);
      default: ;
    endcase
  end

  assign out_if.valid          = out_valid_r;
  assign out_if.sample_out     = out_sample_r;
  assign out_if.delay_too_long = out_flag_r;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  `FDL_ASSERT_NEXT(a_len_write_clears, clk, rst_n, len_wr, !in_if.ready && (pos_r == '0))
  `FDL_ASSERT_NOW(a_pos_in_range, clk, rst_n, 1'b1, LW'(pos_r) < len_r)
  `FDL_ASSERT_NEXT(a_one_at_a_time, clk, rst_n, in_if.valid && in_if.ready, !in_if.ready)
  `FDL_ASSERT_NOW(a_too_long_zero, clk, rst_n, out_if.valid && out_if.delay_too_long,
                  out_if.sample_out == '0)

endmodule

`default_nettype wire

>>> rtl/fdl_store.sv
// Sample store: one write port, one read port with registered read data.
`default_nettype none

module fdl_store #(
  parameter int DEPTH = 262144,
  parameter int WIDTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

>>> rtl/fdl_mac.sv
// Shared multiply-accumulate unit.
`default_nettype none

module fdl_mac
  import fdl_pkg::*;
#(
  parameter int A_W   = 16,
  parameter int ACC_W = 36
) (
  input  wire logic                    clk,
  input  wire mac_ctl_t                ctl,
  input  wire logic signed [A_W-1:0]   op_a,
  input  wire logic signed [COEF_W-1:0] op_b,
  input  wire logic signed [ACC_W-1:0] init,
  output logic signed      [ACC_W-1:0] acc
);

  logic signed [A_W+COEF_W-1:0] prod;
  logic signed [ACC_W-1:0]      acc_r;
  logic signed [ACC_W-1:0]      acc_nxt;

  assign prod    = op_a * op_b;
  assign acc_nxt = (ctl.start ? init : acc_r) + ACC_W'(prod);

  always_ff @(posedge clk) begin
    if (ctl.start || ctl.en) begin
      acc_r <= acc_nxt;
    end
  end

  assign acc = acc_r;

endmodule

`default_nettype wire
